[src/ppsc_pkg.sv]
// ----------------------------------------------------------------------------
// ppsc_pkg
// shared types, fixed-point constants and elaboration-time tables for the
// pure pursuit speed and steering controller
// ----------------------------------------------------------------------------
package ppsc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_DEPTH        = 32;
  localparam int TAB_IDX_W        = 5;

  // datapath widths
  localparam int XY_W   = 60;  // cordic x/y, mm scaled by 2^30
  localparam int Z_W    = 45;  // angles, radians q40
  localparam int SQ_W   = 49;  // squared distance
  localparam int ROOT_W = 25;  // distance in mm
  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [MUL_W-1:0] DEG10_Q16   = 32'd37549362;
  localparam int               STEER_LIMIT = 12868;
  localparam logic [6:0]       ACCEL_FULL  = 7'd100;
  localparam int               STEER_BIAS  = 90;

  typedef enum logic [1:0] {
    REG_TARGET_SPEED = 2'd0,
    REG_BRAKE_GAIN   = 2'd1,
    REG_WHEEL_BASE   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CM_VECTOR,
    CM_ROTATE
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SPEED_MUL,
    ST_SPEED_SAT,
    ST_DX_MUL,
    ST_DY_MUL,
    ST_D2_SUM,
    ST_VEC_WAIT,
    ST_ALPHA_SUB,
    ST_WRAP_HI,
    ST_WRAP_LO,
    ST_FOLD_HI,
    ST_FOLD_LO,
    ST_SIN_GO,
    ST_SIN_WAIT,
    ST_NUM_MUL,
    ST_STEER_GO,
    ST_STEER_WAIT,
    ST_STEER_RND,
    ST_DEG_MUL,
    ST_DEG_RND,
    ST_DONE
  } state_t;

  typedef logic signed [Z_W-1:0] atan_tab_t [TAB_DEPTH];

  // shift-subtract division, only evaluated at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64c(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(1/n) in q40 by the integer series
  function automatic logic signed [63:0] atan_inv(input logic [63:0] n);
    logic [63:0]        p;
    logic [63:0]        nn;
    logic [63:0]        k;
    logic [63:0]        t;
    logic signed [63:0] s;
    p  = udiv64(64'd1 << 40, n);
    nn = n * n;
    k  = '0;
    s  = '0;
    while (p != 0) begin
      t = udiv64(p, 2 * k + 1);
      if (k[0]) s = s - signed'(t);
      else      s = s + signed'(t);
      p = udiv64(p, nn);
      k = k + 1;
    end
    return s;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = Z_W'(atan_inv(64'd2) + atan_inv(64'd3));
    for (int i = 1; i < TAB_DEPTH; i++) begin
      tab[i] = Z_W'(atan_inv(64'd1 << i));
    end
    return tab;
  endfunction

  // gain-corrected start value for the sine rotation, q30
  function automatic logic [63:0] sin_x0(input int n);
    logic [63:0] g;
    logic [63:0] gr;
    g = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      g = g + (g >> (2 * i));
    end
    gr = isqrt64c(g << 30);
    return udiv64((64'd1 << 60) + (gr >> 1), gr);
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();
  localparam logic signed [Z_W-1:0] HALF_PI = ATAN_TAB[0] <<< 1;
  localparam logic signed [Z_W-1:0] PI_Q40  = ATAN_TAB[0] <<< 2;
  localparam logic signed [Z_W-1:0] TWO_PI  = ATAN_TAB[0] <<< 3;

endpackage

[src/ppsc_mul.sv]
// ----------------------------------------------------------------------------
// ppsc_mul
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module ppsc_mul (
  input  logic                                  clk,
  input  logic signed [ppsc_pkg::MUL_W-1:0]     a,
  input  logic signed [ppsc_pkg::MUL_W-1:0]     b,
  output logic signed [ppsc_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[src/ppsc_isqrt.sv]
// ----------------------------------------------------------------------------
// ppsc_isqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ppsc_isqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ppsc_pkg::SQ_W-1:0]         value,
  output logic                              busy,
  output logic [ppsc_pkg::ROOT_W-1:0]       root
);

  localparam int W = ppsc_pkg::SQ_W + 1;

  logic [W-1:0] rem;
  logic [W-1:0] r;
  logic [W-1:0] b;
  logic [W-1:0] trial;
  logic         fits;

  assign trial = r + b;
  assign fits  = rem >= trial;
  assign root  = r[ppsc_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && b[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= W'(value);
      r   <= '0;
      b   <= W'(1) << (ppsc_pkg::SQ_W - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial;
        r   <= (r >> 1) + b;
      end else begin
        r   <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

[src/ppsc_cordic.sv]
// ----------------------------------------------------------------------------
// ppsc_cordic
// iterative cordic, vectoring for atan2 and rotation for sine
// ----------------------------------------------------------------------------
module ppsc_cordic #(
  parameter int CORDIC_STEPS = ppsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppsc_pkg::cordic_req_t             req,
  input  logic signed [ppsc_pkg::XY_W-1:0]  x0,
  input  logic signed [ppsc_pkg::XY_W-1:0]  y0,
  input  logic signed [ppsc_pkg::Z_W-1:0]   z0,
  output logic                              busy,
  output logic signed [ppsc_pkg::XY_W-1:0]  y,
  output logic signed [ppsc_pkg::Z_W-1:0]   z
);

  localparam logic signed [ppsc_pkg::XY_W-1:0] SIN_X0 =
    ppsc_pkg::XY_W'(ppsc_pkg::sin_x0(CORDIC_STEPS));
  localparam logic [ppsc_pkg::TAB_IDX_W-1:0] LAST =
    ppsc_pkg::TAB_IDX_W'(CORDIC_STEPS - 1);

  logic signed [ppsc_pkg::XY_W-1:0]  x;
  logic [ppsc_pkg::TAB_IDX_W-1:0]    idx;
  ppsc_pkg::cordic_mode_t            mode;
  logic signed [ppsc_pkg::XY_W-1:0]  xs;
  logic signed [ppsc_pkg::XY_W-1:0]  ys;
  logic signed [ppsc_pkg::Z_W-1:0]   ang;
  logic                              plus;

  always_comb begin
    xs  = x >>> idx;
    ys  = y >>> idx;
    ang = ppsc_pkg::ATAN_TAB[idx];
    if (mode == ppsc_pkg::CM_VECTOR) begin
      plus = y > 0;
    end else begin
      plus = z[ppsc_pkg::Z_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= !(req.mode == ppsc_pkg::CM_VECTOR && y0 == 0);
    end else if (busy && idx == LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      idx  <= '0;
      if (req.mode == ppsc_pkg::CM_ROTATE) begin
        x <= SIN_X0;
        y <= '0;
        z <= z0;
      end else if (y0 == 0) begin
        // degenerate vector: angle is 0, or pi on the negative x axis
        x <= x0;
        y <= y0;
        z <= x0[ppsc_pkg::XY_W-1] ? ppsc_pkg::PI_Q40 : '0;
      end else if (x0[ppsc_pkg::XY_W-1]) begin
        x <= -x0;
        y <= -y0;
        z <= (y0 > 0) ? ppsc_pkg::PI_Q40 : -ppsc_pkg::PI_Q40;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (plus) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end
    end
  end

endmodule

[src/pure_pursuit_speed_steer_control.sv]
// ----------------------------------------------------------------------------
// pure_pursuit_speed_steer_control
// proportional speed control and pure pursuit steering, one item per tick
// ----------------------------------------------------------------------------
// steps: without a path only the speed terms; with one also a square root,
//   two atan2 passes and one sine pass of the shared cordic
// throughput: one item at a time, req_stall is high until the result is
//   handed to the output register, which holds it while rsp_stall is high
// reset: rst is synchronous, clears configuration registers, held actuator values and fsm
// ----------------------------------------------------------------------------
module pure_pursuit_speed_steer_control #(
  parameter int CORDIC_STEPS = ppsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppsc_pkg::APB_AW-1:0]        paddr,
  input  logic [ppsc_pkg::APB_DW-1:0]        pwdata,
  output logic [ppsc_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  // input items
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic signed [23:0]                 pos_x,
  input  logic signed [23:0]                 pos_y,
  input  logic signed [15:0]                 heading,
  input  logic signed [15:0]                 speed,
  input  logic signed [23:0]                 goal_x,
  input  logic signed [23:0]                 goal_y,
  input  logic                               path_valid,
  // result items
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [15:0]                        accel_cmd,
  output logic [15:0]                        brake_cmd,
  output logic signed [14:0]                 steer_angle,
  output logic [6:0]                         act_accel,
  output logic signed [10:0]                 act_steer
);

  localparam int XY_W   = ppsc_pkg::XY_W;
  localparam int Z_W    = ppsc_pkg::Z_W;
  localparam int MUL_W  = ppsc_pkg::MUL_W;
  localparam int PROD_W = ppsc_pkg::PROD_W;
  localparam int SQ_W   = ppsc_pkg::SQ_W;
  localparam int ROOT_W = ppsc_pkg::ROOT_W;

  localparam logic [Z_W-1:0] STEER_HALF = Z_W'(1) << 26;
  localparam logic [40:0]    DEG_HALF   = 41'(1) << 28;

  // configuration registers
  logic [14:0] cfg_target_speed;
  logic [15:0] cfg_brake_gain;
  logic [12:0] cfg_wheel_base;

  // captured item
  logic signed [23:0] cap_pos_x;
  logic signed [23:0] cap_pos_y;
  logic signed [15:0] cap_heading;
  logic signed [15:0] cap_speed;
  logic signed [23:0] cap_goal_x;
  logic signed [23:0] cap_goal_y;
  logic               cap_path_valid;

  // working results
  logic [15:0]        res_accel;
  logic [15:0]        res_brake;
  logic signed [14:0] res_steer;
  logic [6:0]         held_act_accel;
  logic signed [10:0] held_act_steer;
  logic [SQ_W-1:0]    d2;
  logic signed [Z_W-1:0] alpha;

  ppsc_pkg::state_t state, state_next;

  logic in_take;
  logic out_free;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_take   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = state != ppsc_pkg::ST_IDLE;

  // --------------------------------------------------------------------------
  // register file
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_target_speed <= '0;
      cfg_brake_gain   <= '0;
      cfg_wheel_base   <= '0;
    end else if (cfg_write) begin
      case (ppsc_pkg::reg_idx_t'(paddr[3:2]))
        ppsc_pkg::REG_TARGET_SPEED: cfg_target_speed <= pwdata[14:0];
        ppsc_pkg::REG_BRAKE_GAIN:   cfg_brake_gain   <= pwdata[15:0];
        ppsc_pkg::REG_WHEEL_BASE:   cfg_wheel_base   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ppsc_pkg::reg_idx_t'(paddr[3:2]))
      ppsc_pkg::REG_TARGET_SPEED: prdata = 32'(cfg_target_speed);
      ppsc_pkg::REG_BRAKE_GAIN:   prdata = 32'(cfg_brake_gain);
      ppsc_pkg::REG_WHEEL_BASE:   prdata = 32'(cfg_wheel_base);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared units
  // --------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  ppsc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic              sq_start;
  logic [SQ_W-1:0]   sq_in;
  logic              sq_busy;
  logic [ROOT_W-1:0] root_dist;

  ppsc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_in),
    .busy  (sq_busy),
    .root  (root_dist)
  );

  ppsc_pkg::cordic_req_t cor_req;
  logic signed [XY_W-1:0] cor_x0;
  logic signed [XY_W-1:0] cor_y0;
  logic signed [Z_W-1:0]  cor_z0;
  logic                   cor_busy;
  logic signed [XY_W-1:0] cor_y;
  logic signed [Z_W-1:0]  cor_z;

  ppsc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cor_req),
    .x0   (cor_x0),
    .y0   (cor_y0),
    .z0   (cor_z0),
    .busy (cor_busy),
    .y    (cor_y),
    .z    (cor_z)
  );

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  // speed error, target minus measured
  logic signed [17:0] err;
  logic               err_neg;
  logic [16:0]        err_mag;
  logic [32:0]        brake_sum;
  logic [15:0]        brake_sat;
  logic [15:0]        accel_sat;

  assign err       = signed'(18'(cfg_target_speed)) - 18'(cap_speed);
  assign err_neg   = err[17];
  assign err_mag   = err_neg ? 17'(-err) : 17'(err);
  assign brake_sum = {1'b0, prod[31:0]} + 33'd128;
  assign brake_sat = (brake_sum[32:8] > 25'd65535) ? 16'hFFFF : brake_sum[23:8];
  assign accel_sat = (err > 18'sd65535) ? 16'hFFFF : err[15:0];

  // vector to the look-ahead point
  logic signed [24:0] dx;
  logic signed [24:0] dy;

  assign dx    = 25'(cap_goal_x) - 25'(cap_pos_x);
  assign dy    = 25'(cap_goal_y) - 25'(cap_pos_y);
  assign sq_in = d2 + prod[SQ_W-1:0];

  // steering angle from q40 to q13, rounded half away from zero, then clamped
  logic            z_neg;
  logic [Z_W-1:0]  z_mag;
  logic [Z_W-1:0]  z_sum;
  logic signed [18:0] steer_full;
  logic signed [18:0] steer_clamp;

  always_comb begin
    z_neg      = cor_z[Z_W-1];
    z_mag      = z_neg ? Z_W'(-cor_z) : Z_W'(cor_z);
    z_sum      = z_mag + STEER_HALF;
    steer_full = z_neg ? -signed'({1'b0, z_sum[Z_W-1:27]})
                       :  signed'({1'b0, z_sum[Z_W-1:27]});
    if (steer_full > 19'(ppsc_pkg::STEER_LIMIT)) begin
      steer_clamp = 19'(ppsc_pkg::STEER_LIMIT);
    end else if (steer_full < -19'(ppsc_pkg::STEER_LIMIT)) begin
      steer_clamp = -19'(ppsc_pkg::STEER_LIMIT);
    end else begin
      steer_clamp = steer_full;
    end
  end

  // tenth-degrees, rounded half away from zero
  logic               p_neg;
  logic [40:0]        p_mag;
  logic [40:0]        p_sum;
  logic signed [12:0] deg10;
  logic signed [12:0] act_steer_full;

  always_comb begin
    p_neg          = prod[PROD_W-1];
    p_mag          = p_neg ? 41'(-prod) : 41'(prod);
    p_sum          = p_mag + DEG_HALF;
    deg10          = p_neg ? -signed'({1'b0, p_sum[40:29]})
                           :  signed'({1'b0, p_sum[40:29]});
    act_steer_full = 13'(ppsc_pkg::STEER_BIAS) - deg10;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    sq_start     = 1'b0;
    cor_req      = '{start: 1'b0, mode: ppsc_pkg::CM_VECTOR};
    cor_x0       = XY_W'(dx) <<< 30;
    cor_y0       = XY_W'(dy) <<< 30;
    cor_z0       = alpha;
    case (state)
      ppsc_pkg::ST_IDLE: begin
        if (in_take) state_next = ppsc_pkg::ST_SPEED_MUL;
      end
      ppsc_pkg::ST_SPEED_MUL: begin
        mul_a      = MUL_W'(err_mag);
        mul_b      = MUL_W'(cfg_brake_gain);
        state_next = ppsc_pkg::ST_SPEED_SAT;
      end
      ppsc_pkg::ST_SPEED_SAT: begin
        state_next = cap_path_valid ? ppsc_pkg::ST_DX_MUL : ppsc_pkg::ST_DONE;
      end
      ppsc_pkg::ST_DX_MUL: begin
        mul_a      = MUL_W'(dx);
        mul_b      = MUL_W'(dx);
        state_next = ppsc_pkg::ST_DY_MUL;
      end
      ppsc_pkg::ST_DY_MUL: begin
        mul_a      = MUL_W'(dy);
        mul_b      = MUL_W'(dy);
        state_next = ppsc_pkg::ST_D2_SUM;
      end
      ppsc_pkg::ST_D2_SUM: begin
        // distance root and bearing run side by side
        sq_start   = 1'b1;
        cor_req    = '{start: 1'b1, mode: ppsc_pkg::CM_VECTOR};
        state_next = ppsc_pkg::ST_VEC_WAIT;
      end
      ppsc_pkg::ST_VEC_WAIT: begin
        if (!sq_busy && !cor_busy) state_next = ppsc_pkg::ST_ALPHA_SUB;
      end
      ppsc_pkg::ST_ALPHA_SUB: state_next = ppsc_pkg::ST_WRAP_HI;
      ppsc_pkg::ST_WRAP_HI:   state_next = ppsc_pkg::ST_WRAP_LO;
      ppsc_pkg::ST_WRAP_LO:   state_next = ppsc_pkg::ST_FOLD_HI;
      ppsc_pkg::ST_FOLD_HI:   state_next = ppsc_pkg::ST_FOLD_LO;
      ppsc_pkg::ST_FOLD_LO:   state_next = ppsc_pkg::ST_SIN_GO;
      ppsc_pkg::ST_SIN_GO: begin
        cor_req    = '{start: 1'b1, mode: ppsc_pkg::CM_ROTATE};
        state_next = ppsc_pkg::ST_SIN_WAIT;
      end
      ppsc_pkg::ST_SIN_WAIT: begin
        if (!cor_busy) state_next = ppsc_pkg::ST_NUM_MUL;
      end
      ppsc_pkg::ST_NUM_MUL: begin
        mul_a      = signed'(cor_y[MUL_W-1:0]);
        mul_b      = MUL_W'(cfg_wheel_base);
        state_next = ppsc_pkg::ST_STEER_GO;
      end
      ppsc_pkg::ST_STEER_GO: begin
        // numerator 2*L*sin(alpha), denominator distance in q30
        cor_req    = '{start: 1'b1, mode: ppsc_pkg::CM_VECTOR};
        cor_y0     = signed'({prod[XY_W-2:0], 1'b0});
        cor_x0     = XY_W'(root_dist) <<< 30;
        state_next = ppsc_pkg::ST_STEER_WAIT;
      end
      ppsc_pkg::ST_STEER_WAIT: begin
        if (!cor_busy) state_next = ppsc_pkg::ST_STEER_RND;
      end
      ppsc_pkg::ST_STEER_RND: state_next = ppsc_pkg::ST_DEG_MUL;
      ppsc_pkg::ST_DEG_MUL: begin
        mul_a      = MUL_W'(res_steer);
        mul_b      = signed'(ppsc_pkg::DEG10_Q16);
        state_next = ppsc_pkg::ST_DEG_RND;
      end
      ppsc_pkg::ST_DEG_RND: state_next = ppsc_pkg::ST_DONE;
      ppsc_pkg::ST_DONE: begin
        if (out_free) state_next = ppsc_pkg::ST_IDLE;
      end
      default: state_next = ppsc_pkg::ST_IDLE;
    endcase
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cap_pos_x      <= pos_x;
      cap_pos_y      <= pos_y;
      cap_heading    <= heading;
      cap_speed      <= speed;
      cap_goal_x     <= goal_x;
      cap_goal_y     <= goal_y;
      cap_path_valid <= path_valid;
    end
    case (state)
      ppsc_pkg::ST_SPEED_SAT: begin
        res_accel <= err_neg ? '0 : accel_sat;
        res_brake <= err_neg ? brake_sat : '0;
        res_steer <= '0;
      end
      ppsc_pkg::ST_DY_MUL:    d2 <= prod[SQ_W-1:0];
      ppsc_pkg::ST_ALPHA_SUB: alpha <= cor_z - (Z_W'(cap_heading) <<< 27);
      ppsc_pkg::ST_WRAP_HI: begin
        if (alpha > ppsc_pkg::PI_Q40) alpha <= alpha - ppsc_pkg::TWO_PI;
      end
      ppsc_pkg::ST_WRAP_LO: begin
        if (alpha < -ppsc_pkg::PI_Q40) alpha <= alpha + ppsc_pkg::TWO_PI;
      end
      ppsc_pkg::ST_FOLD_HI: begin
        // fold into the half plane the sine rotation covers
        if (alpha > ppsc_pkg::HALF_PI) alpha <= ppsc_pkg::PI_Q40 - alpha;
      end
      ppsc_pkg::ST_FOLD_LO: begin
        if (alpha < -ppsc_pkg::HALF_PI) alpha <= -ppsc_pkg::PI_Q40 - alpha;
      end
      ppsc_pkg::ST_STEER_RND: res_steer <= 15'(steer_clamp);
      default: ;
    endcase
  end

  // held actuator values
  always_ff @(posedge clk) begin
    if (rst) begin
      held_act_accel <= '0;
      held_act_steer <= '0;
    end else begin
      if (state == ppsc_pkg::ST_SPEED_SAT && !err_neg) begin
        held_act_accel <= ppsc_pkg::ACCEL_FULL;
      end
      if (state == ppsc_pkg::ST_DEG_RND) begin
        held_act_steer <= 11'(act_steer_full);
      end
    end
  end

  // output register, parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ppsc_pkg::ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppsc_pkg::ST_DONE && out_free) begin
      accel_cmd   <= res_accel;
      brake_cmd   <= res_brake;
      steer_angle <= res_steer;
      act_accel   <= held_act_accel;
      act_steer   <= held_act_steer;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_units_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    state == ppsc_pkg::ST_IDLE |-> !sq_busy && !cor_busy)
    else $error("shared unit still running while idle");

  a_accel_levels: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> act_accel == 7'd0 || act_accel == ppsc_pkg::ACCEL_FULL)
    else $error("actuator accel off its two levels");

  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> steer_angle <= 15'sd12868 && steer_angle >= -15'sd12868)
    else $error("steering angle outside clamp");

  a_accel_brake_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> accel_cmd == 16'd0 || brake_cmd == 16'd0)
    else $error("accel and brake both active");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pure pursuit speed and steering controller:
// a directed table followed by random control ticks over several register
// settings, each result compared field by field with the table or a bit-true predictor
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STEPS      = ppsc_pkg::CORDIC_STEPS_DEF;
  localparam int DRAIN_CYC  = 2 * STEPS + 80;  // settle time after the last result
  localparam int N_PHASES   = 6;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_CYC   = 600;
  localparam int AW         = ppsc_pkg::APB_AW;
  localparam int DW         = ppsc_pkg::APB_DW;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] hd;
    logic signed [15:0] sp;
    logic signed [23:0] gx;
    logic signed [23:0] gy;
    logic               pv;
  } tick_t;

  typedef struct {
    logic [15:0]        accel;
    logic [15:0]        brake;
    logic signed [14:0] steer;
    logic [6:0]         act_a;
    logic signed [10:0] act_s;
  } cmd_t;

  typedef struct {
    tick_t t;
    bit    known;
    cmd_t  c;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic          pready;

  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [23:0] pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
  logic signed [15:0] heading = '0, speed = '0;
  logic path_valid = 1'b0;

  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [15:0] accel_cmd, brake_cmd;
  logic signed [14:0] steer_angle;
  logic [6:0] act_accel;
  logic signed [10:0] act_steer;

  // tags that travel with the item on the bus
  bit   cur_known = 0;
  cmd_t cur_cmd;

  pure_pursuit_speed_steer_control DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid, .req_stall, .pos_x, .pos_y, .heading, .speed, .goal_x, .goal_y,
    .path_valid, .rsp_valid, .rsp_stall, .accel_cmd, .brake_cmd, .steer_angle,
    .act_accel, .act_steer
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor state: registers, held actuator values, angle tables
  // ---------------------------------------------------------------------------
  longint unsigned cfg_target = 0, cfg_gain = 0, cfg_wb = 0;
  longint unsigned hold_accel = 0;
  longint          hold_steer = 0;
  longint          atan_q40 [ppsc_pkg::TAB_DEPTH];
  longint          pi_q40;
  longint          sin_start;

  int   errors = 0;
  cmd_t cmd_q[$];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // arctangent of 1/n in q40 from the alternating series
  function automatic longint arctan_recip(longint unsigned n);
    longint unsigned p = (64'd1 << 40) / n, nn = n * n, k = 0, t;
    longint s = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) s = s - longint'(t);
      else      s = s + longint'(t);
      p = p / nn;
      k++;
    end
    return s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint unsigned half = 64'd1 << (s - 1);
    if (v < 0) return -longint'((longint'(-v) + half) >> s);
    return longint'((longint'(v) + half) >> s);
  endfunction

  // vectoring pass, q40 angle of (x, y)
  function automatic longint bearing(longint y, longint x);
    longint z = 0, xs, ys;
    if (y == 0) return (x < 0) ? pi_q40 : 0;
    if (x < 0) begin
      z = (y > 0) ? pi_q40 : -pi_q40;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_q40[i];
      end else begin
        x -= ys; y += xs; z -= atan_q40[i];
      end
    end
    return z;
  endfunction

  // rotation pass, sine in q30 of a q40 angle within +-pi/2
  function automatic longint sine_q30(longint z);
    longint x = sin_start, y = 0, xs, ys;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q40[i];
      end else begin
        x += ys; y -= xs; z += atan_q40[i];
      end
    end
    return y;
  endfunction

  function automatic void build_tables();
    longint unsigned g = 64'd1 << 30, gr;
    atan_q40[0] = arctan_recip(2) + arctan_recip(3);
    for (int i = 1; i < ppsc_pkg::TAB_DEPTH; i++) atan_q40[i] = arctan_recip(64'd1 << i);
    pi_q40 = 4 * atan_q40[0];
    for (int i = 0; i < STEPS; i++) g = g + (g >> (2 * i));
    gr = root64(g << 30);
    sin_start = longint'(((64'd1 << 60) + gr / 2) / gr);
  endfunction

  // one control tick: speed loop, pure pursuit, held actuator values
  function automatic cmd_t control_tick(tick_t t);
    cmd_t c;
    longint err, dx, dy, alpha, s, num, steer = 0, deg10;
    longint unsigned p, d;
    err = longint'(cfg_target) - longint'(t.sp);
    c.accel = 0;
    c.brake = 0;
    if (err < 0) begin
      p = (longint'(-err) * cfg_gain + 128) >> 8;
      c.brake = (p > 65535) ? 16'hFFFF : p[15:0];
    end else begin
      c.accel = (err > 65535) ? 16'hFFFF : err[15:0];
      hold_accel = 100;
    end
    if (t.pv) begin
      dx = longint'(t.gx) - longint'(t.px);
      dy = longint'(t.gy) - longint'(t.py);
      d = root64(longint'(dx * dx) + longint'(dy * dy));
      alpha = bearing(dy * (64'sd1 << 30), dx * (64'sd1 << 30))
              - longint'(t.hd) * (64'sd1 << 27);
      if (alpha > pi_q40) alpha -= 2 * pi_q40;
      if (alpha < -pi_q40) alpha += 2 * pi_q40;
      if (alpha > pi_q40 / 2) alpha = pi_q40 - alpha;
      if (alpha < -(pi_q40 / 2)) alpha = -pi_q40 - alpha;
      s = sine_q30(alpha);
      num = 2 * longint'(cfg_wb) * s;
      if (num == 0 && d == 0) steer = 0;
      else steer = round_shift(bearing(num, longint'(d) * (64'sd1 << 30)), 27);
      if (steer > ppsc_pkg::STEER_LIMIT) steer = ppsc_pkg::STEER_LIMIT;
      if (steer < -ppsc_pkg::STEER_LIMIT) steer = -ppsc_pkg::STEER_LIMIT;
      deg10 = round_shift(steer * longint'(ppsc_pkg::DEG10_Q16), 29);
      hold_steer = ppsc_pkg::STEER_BIAS - deg10;
    end
    c.steer = steer[14:0];
    c.act_a = hold_accel[6:0];
    c.act_s = hold_steer[10:0];
    return c;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // monitors: item acceptance feeds the predictor, result acceptance checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_t t;
    cmd_t  c, want;
    if (!rst && req_valid && !req_stall) begin
      t = '{pos_x, pos_y, heading, speed, goal_x, goal_y, path_valid};
      c = control_tick(t);
      cmd_q.push_back(cur_known ? cur_cmd : c);
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (cmd_q.size() == 0) begin
        report("items outstanding", 1, 0);
      end else begin
        want = cmd_q.pop_front();
        if (accel_cmd !== want.accel) report("accel_cmd", want.accel, accel_cmd);
        if (brake_cmd !== want.brake) report("brake_cmd", want.brake, brake_cmd);
        if (steer_angle !== want.steer) report("steer_angle", want.steer, steer_angle);
        if (act_accel !== want.act_a) report("act_accel", want.act_a, act_accel);
        if (act_steer !== want.act_s) report("act_steer", want.act_s, act_steer);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus a long hold-off that fills the block
  // ---------------------------------------------------------------------------
  int recv_idle_pct = 0;
  int send_idle_pct = 0;
  bit long_hold     = 0;  // raised once by the stimulus
  int hold_cnt      = 0;  // cycles held off so far

  always @(negedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYC) begin
      hold_cnt  <= hold_cnt + 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // sender and register access
  // ---------------------------------------------------------------------------
  task automatic send_tick(tick_t t, bit known, cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    pos_x      <= t.px;
    pos_y      <= t.py;
    heading    <= t.hd;
    speed      <= t.sp;
    goal_x     <= t.gx;
    goal_y     <= t.gy;
    path_valid <= t.pv;
    cur_known  <= known;
    cur_cmd    <= c;
    do @(posedge clk); while (req_stall);
  endtask

  // write one register, read it back
  task automatic reg_write(ppsc_pkg::reg_idx_t idx, logic [DW-1:0] val);
    logic [DW-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) report("register readback", val, rd);
    case (idx)
      ppsc_pkg::REG_TARGET_SPEED: cfg_target = val;
      ppsc_pkg::REG_BRAKE_GAIN:   cfg_gain   = val;
      default:                    cfg_wb     = val;
    endcase
  endtask

  task automatic set_config(int ts, int bg, int wb);
    reg_write(ppsc_pkg::REG_TARGET_SPEED, ts);
    reg_write(ppsc_pkg::REG_BRAKE_GAIN, bg);
    reg_write(ppsc_pkg::REG_WHEEL_BASE, wb);
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic tick_t mk(int px, int py, int hd, int sp, int gx, int gy, bit pv);
    tick_t t;
    t = '{px[23:0], py[23:0], hd[15:0], sp[15:0], gx[23:0], gy[23:0], pv};
    return t;
  endfunction

  function automatic cmd_t cmd(int a, int b, int s, int aa, int as_);
    cmd_t c;
    c = '{a[15:0], b[15:0], s[14:0], aa[6:0], as_[10:0]};
    return c;
  endfunction

  // mostly a nearby look-ahead point and a sane heading, some raw noise
  function automatic tick_t rand_tick();
    tick_t t;
    int base_x, base_y, v;
    if ($urandom_range(99) < 70) begin
      base_x = int'($urandom_range(8388607)) - 4194304;
      base_y = int'($urandom_range(8388607)) - 4194304;
      t.px = base_x[23:0];
      t.py = base_y[23:0];
      v = base_x + int'($urandom_range(40000)) - 20000;
      t.gx = v[23:0];
      v = base_y + int'($urandom_range(40000)) - 20000;
      t.gy = v[23:0];
      v = int'($urandom_range(51472)) - 25736;
      t.hd = v[15:0];
      v = int'(cfg_target) + int'($urandom_range(4000)) - 2000;
      t.sp = v[15:0];
      t.pv = ($urandom_range(99) < 85);
    end else begin
      v = $urandom;
      t.px = v[23:0];
      v = $urandom;
      t.py = v[23:0];
      v = $urandom;
      t.gx = v[23:0];
      v = $urandom;
      t.gy = v[23:0];
      v = $urandom;
      t.hd = v[15:0];
      v = $urandom;
      t.sp = v[15:0];
      v = $urandom;
      t.pv = v[0];
    end
    return t;
  endfunction

  row_t dir_rows[$];

  initial begin
    cmd_t  none;
    tick_t t;
    none = cmd(0, 0, 0, 0, 0);
    build_tables();

    // reset registers: target 0, gain 0, wheel base 0
    dir_rows.push_back('{mk(0, 0, 0, 32767, 0, 0, 0), 1, cmd(0, 0, 0, 0, 0)});
    // zero speed error latches full accel
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1, cmd(0, 0, 0, 100, 0)});
    dir_rows.push_back('{mk(0, 0, 0, -32768, 0, 0, 0), 1, cmd(32768, 0, 0, 100, 0)});
    // goal at the vehicle with no wheel base
    dir_rows.push_back('{mk(500, -500, 0, 0, 500, -500, 1), 1, cmd(0, 0, 0, 100, 90)});
    // zero wheel base, far goal
    dir_rows.push_back('{mk(0, 0, 1000, 0, 3000, 4000, 1), 1, cmd(0, 0, 0, 100, 90)});
    // no path holds the actuator steering
    dir_rows.push_back('{mk(7, 7, 7, 0, 9, 9, 0), 1, cmd(0, 0, 0, 100, 90)});
    // from this row on the gain and wheel base are at maximum
    dir_rows.push_back('{mk(-8388608, -8388608, 32767, 0, 8388607, 8388607, 1), 0, none});
    dir_rows.push_back('{mk(8388607, 0, 0, 100, 8388607, 0, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, 25736, 5, 3000, 0, 1), 0, none});
    // goal straight behind, zero y: bearing pi
    dir_rows.push_back('{mk(1000, 0, -32768, -5, -1000, 0, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, -25736, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, 12868, 0, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 2000, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, -2000, 1), 0, none});
    dir_rows.push_back('{mk(-1, -1, -1, -1, -1, -1, 1), 0, none});
    // brake saturation at maximum gain
    dir_rows.push_back('{mk(0, 0, 0, 32767, 0, 0, 1), 0, none});
    dir_rows.push_back('{mk(0, 0, 0, 1, 0, 0, 0), 0, none});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, the first six rows under the reset register values
    foreach (dir_rows[i]) begin
      if (i == 6) begin
        @(negedge clk);
        req_valid <= 1'b0;
        drain();
        set_config(0, 65535, 8191);
      end
      send_tick(dir_rows[i].t, dir_rows[i].known, dir_rows[i].c);
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      @(negedge clk);
      req_valid <= 1'b0;
      drain();
      case (ph)
        0: set_config($urandom_range(32767), $urandom_range(65535), $urandom_range(8191));
        1: set_config(32767, 65535, 8191);
        2: set_config(0, 0, 0);
        3: set_config($urandom_range(32767), $urandom_range(1024), $urandom_range(50));
        4: set_config(16384, 256, 2700);
        default: set_config($urandom_range(32767), $urandom_range(65535), $urandom_range(8191));
      endcase
      if (ph < 2) begin
        send_idle_pct = 14; recv_idle_pct = 53;
      end else if (ph < 4) begin
        send_idle_pct = 53; recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      // long receiver hold-off while items keep coming
      if (ph == 4) long_hold = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        t = rand_tick();
        send_tick(t, 0, none);
      end
    end
    @(negedge clk);
    req_valid <= 1'b0;
    drain();

    if (errors == 0 && cmd_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
